/* rtl/ple_pkg.sv */
package ple_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACT_W    = 3;
  localparam int POS_W    = 8;
  localparam int POS2_W   = 7;
  localparam int DATA_W   = 32;
  localparam int OCNT_W   = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_READ      = 3'd2,
    ACT_EXCHANGE  = 3'd3,
    ACT_REMOVE_VAL = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SWAP
  } cell_op_t;

  typedef struct packed {
    logic              eval;
    logic              apply;
    cell_op_t          op;
    logic              by_value;
    logic [POS_W-1:0]  pos;
    logic [POS2_W-1:0] pos2;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
  } cell_ctl_t;

endpackage

/* rtl/ple_if.sv */
interface ple_in_if;
  import ple_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [POS_W-1:0]    position;
  logic [POS2_W-1:0]   second_position;
  logic [DATA_W-1:0]   value;
  modport source (output valid, action, position, second_position, value, input ready);
  modport sink   (input valid, action, position, second_position, value, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;
  logic                valid;
  logic                ready;
  logic                status;
  logic [DATA_W-1:0]   read_value;
  logic [OCNT_W-1:0]   entry_count;
  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

/* rtl/ple_cell.sv */
module ple_cell import ple_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  input  logic              seen_in,
  output logic              seen_out,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap_a,
  output logic [DATA_W-1:0] tap_b
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              shift_r;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  pos2_c;
  logic              live;
  logic              match;

  assign idx_c  = CMP_W'(idx);
  assign pos_c  = CMP_W'(ctl.pos);
  assign pos2_c = CMP_W'(ctl.pos2);
  assign live   = idx_c < CMP_W'(ctl.count);
  assign match  = live && (data_r == ctl.value);

  assign seen_out = seen_in | match;
  assign data     = data_r;
  assign tap_a    = (idx_c == pos_c)  ? data_r : '0;
  assign tap_b    = (idx_c == pos2_c) ? data_r : '0;

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      shift_r <= ctl.by_value ? seen_out : (idx_c >= pos_c);
    end
  end

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (idx_c == pos_c) begin
          data_nxt = ctl.value;
        end else if (idx_c > pos_c) begin
          data_nxt = prev_data;
        end
      end
      CELL_REMOVE: begin
        if (shift_r) begin
          data_nxt = next_data;
        end
      end
      CELL_SWAP: begin
        if (idx_c == pos_c) begin
          data_nxt = ctl.rd_b;
        end else if (idx_c == pos2_c) begin
          data_nxt = ctl.rd_a;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/positional_list_engine_top.sv */
// Ordered list of up to CAPACITY 32-bit words held in a row of cells, one word per cell.
// Each accepted word passes through an evaluate step, in which every cell compares its entry
// and the two addressed entries are gathered, and then an update step, in which all cells
// shift, swap or load together. A result waits in an output register, and the next word is
// taken while it waits; the update step holds only when the previous result has not yet been taken.
// One word is in flight at a time: a new word is taken only after the previous one has been
// accepted, compared and applied.
module positional_list_engine_top import ple_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_port,
  ple_out_if.source out_port
);

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   act_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS2_W-1:0]  pos2_r;
  logic [DATA_W-1:0]  val_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  rd_a_r, rd_b_r;
  logic [DATA_W-1:0]  rd_a, rd_b;
  logic               ok_r, ok_nxt;
  logic               out_valid_r;
  logic               status_r;
  logic [DATA_W-1:0]  read_value_r;
  logic [OCNT_W-1:0]  entry_count_r;
  logic               in_fire;
  logic               apply_go;
  cell_op_t           cell_op;
  cell_ctl_t          ctl;

  logic [DATA_W-1:0]  cell_data [CAPACITY];
  logic [DATA_W-1:0]  cell_tap_a [CAPACITY];
  logic [DATA_W-1:0]  cell_tap_b [CAPACITY];
  logic [CAPACITY:0]  seen;

  logic [CMP_W-1:0]   pos_c, pos2_c, cnt_c;

  assign in_port.ready = (state_r == ST_IDLE);
  assign in_fire       = in_port.valid && in_port.ready;
  assign apply_go      = (state_r == ST_APPLY) && (!out_valid_r || out_port.ready);

  assign pos_c  = CMP_W'(pos_r);
  assign pos2_c = CMP_W'(pos2_r);
  assign cnt_c  = CMP_W'(count_r);

  always_comb begin
    cell_op = CELL_HOLD;
    unique case (act_r)
      ACT_INSERT:     cell_op = CELL_INSERT;
      ACT_REMOVE:     cell_op = CELL_REMOVE;
      ACT_REMOVE_VAL: cell_op = CELL_REMOVE;
      ACT_EXCHANGE:   cell_op = CELL_SWAP;
      default:        cell_op = CELL_HOLD;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.eval     = (state_r == ST_EVAL);
    ctl.apply    = apply_go && ok_r;
    ctl.op       = cell_op;
    ctl.by_value = (act_r == ACT_REMOVE_VAL);
    ctl.pos      = pos_r;
    ctl.pos2     = pos2_r;
    ctl.value    = val_r;
    ctl.count    = count_r;
    ctl.rd_a     = rd_a_r;
    ctl.rd_b     = rd_b_r;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ple_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .ctl       (ctl),
      .prev_data ((g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g - 1]),
      .next_data ((g == CAPACITY - 1) ? cell_data[g]
                                      : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .seen_in   (seen[g]),
      .seen_out  (seen[g+1]),
      .data      (cell_data[g]),
      .tap_a     (cell_tap_a[g]),
      .tap_b     (cell_tap_b[g])
    );
  end

  always_comb begin
    rd_a = '0;
    rd_b = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_a = rd_a | cell_tap_a[i];
      rd_b = rd_b | cell_tap_b[i];
    end
  end

  always_comb begin
    ok_nxt = 1'b0;
    unique case (act_r)
      ACT_INSERT:     ok_nxt = (pos_c <= cnt_c) && (cnt_c < CMP_W'(CAPACITY));
      ACT_REMOVE:     ok_nxt = pos_c < cnt_c;
      ACT_READ:       ok_nxt = pos_c < cnt_c;
      ACT_EXCHANGE:   ok_nxt = (pos_c < cnt_c) && (pos2_c < cnt_c);
      ACT_REMOVE_VAL: ok_nxt = seen[CAPACITY];
      default:        ok_nxt = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (ok_r) begin
      case (act_r)
        ACT_INSERT:     count_nxt = count_r + CNT_W'(1);
        ACT_REMOVE:     count_nxt = count_r - CNT_W'(1);
        ACT_REMOVE_VAL: count_nxt = count_r - CNT_W'(1);
        default:        count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_port.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_port.action;
      pos_r  <= in_port.position;
      pos2_r <= in_port.second_position;
      val_r  <= in_port.value;
    end
    if (state_r == ST_EVAL) begin
      rd_a_r <= rd_a;
      rd_b_r <= rd_b;
      ok_r   <= ok_nxt;
    end
    if (apply_go) begin
      status_r      <= !ok_r;
      read_value_r  <= (ok_r && (act_r == ACT_READ)) ? rd_a_r : '0;
      entry_count_r <= OCNT_W'(count_nxt);
    end
  end

  assign out_port.valid       = out_valid_r;
  assign out_port.status      = status_r;
  assign out_port.read_value  = read_value_r;
  assign out_port.entry_count = entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EVAL))
    else $error("accepted word did not start evaluation");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && !ok_r) |=> (count_r == $past(count_r)))
    else $error("failed action changed the count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_go && ok_r && (act_r == ACT_INSERT)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go |=> out_valid_r)
    else $error("result not posted after update");

endmodule

/* tb/tb.sv */
module tb;
  import ple_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    logic [POS2_W-1:0] second_position;
    logic [DATA_W-1:0] value;
  } list_op_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] read_value;
    logic [OCNT_W-1:0] entry_count;
  } list_result_t;

  localparam int ROUNDS        = 4;
  localparam int BATCH         = 8;
  localparam int BATCHES       = 39;
  localparam int TAIL_CYCLES   = 20;
  localparam int ACT_MAX       = (1 << ACT_W) - 1;
  localparam int POS_MAX       = (1 << POS_W) - 1;
  localparam int POS2_MAX      = (1 << POS2_W) - 1;

  logic clk = 1'b0;
  logic rst_n;

  ple_in_if  cmd_bus ();
  ple_out_if rsp_bus ();

  positional_list_engine_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (cmd_bus),
    .out_port (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [DATA_W-1:0] list_words [CAPACITY];
  int                list_len;
  list_op_t          pending_ops [$];
  list_result_t      predicted_q [$];
  list_op_t          op_on_bus;
  int                sender_idle_pct;
  int                receiver_stall_pct;
  int                ops_taken;
  int                results_seen;
  int                rejected_ops;
  int                full_inserts;
  int                peak_len;
  int                mismatches;

  function automatic void drop_entry(int at);
    int i;
    for (i = at; i + 1 < list_len; i++) begin
      list_words[i] = list_words[i + 1];
    end
    list_len--;
  endfunction

  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t res;
    logic [DATA_W-1:0] held;
    int i;
    int hit;
    res.status = 1'b1;
    res.read_value = '0;
    case (op.action)
      ACT_INSERT: begin
        if (op.position <= list_len && list_len < CAPACITY) begin
          for (i = list_len; i > op.position; i--) begin
            list_words[i] = list_words[i - 1];
          end
          list_words[op.position] = op.value;
          list_len++;
          res.status = 1'b0;
        end else if (list_len == CAPACITY) begin
          full_inserts++;
        end
      end
      ACT_REMOVE: begin
        if (op.position < list_len) begin
          drop_entry(op.position);
          res.status = 1'b0;
        end
      end
      ACT_READ: begin
        if (op.position < list_len) begin
          res.read_value = list_words[op.position];
          res.status = 1'b0;
        end
      end
      ACT_EXCHANGE: begin
        if (op.position < list_len && op.second_position < list_len) begin
          held = list_words[op.position];
          list_words[op.position] = list_words[op.second_position];
          list_words[op.second_position] = held;
          res.status = 1'b0;
        end
      end
      ACT_REMOVE_VAL: begin
        hit = -1;
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == op.value) hit = i;
        end
        if (hit >= 0) begin
          drop_entry(hit);
          res.status = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = OCNT_W'(list_len);
    if (res.status) rejected_ops++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  task automatic push_op(input int unsigned act, input int unsigned pos, input int unsigned pos2,
                         input logic [DATA_W-1:0] val);
    list_op_t op;
    op.action = ACT_W'(act);
    op.position = POS_W'(pos);
    op.second_position = POS2_W'(pos2);
    op.value = val;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random_op(input bit growing);
    int unsigned roll;
    int unsigned len;
    int unsigned act;
    int unsigned pos;
    int unsigned pos2;
    logic [DATA_W-1:0] val;
    len = list_len;
    roll = $urandom_range(0, 99);
    if (growing) begin
      act = roll < 70 ? ACT_INSERT : roll < 75 ? ACT_REMOVE : roll < 79 ? ACT_REMOVE_VAL :
            roll < 88 ? ACT_READ : roll < 97 ? ACT_EXCHANGE :
            $urandom_range(ACT_REMOVE_VAL + 1, ACT_MAX);
    end else begin
      act = roll < 42 ? ACT_REMOVE : roll < 68 ? ACT_REMOVE_VAL : roll < 75 ? ACT_INSERT :
            roll < 85 ? ACT_READ : roll < 95 ? ACT_EXCHANGE :
            $urandom_range(ACT_REMOVE_VAL + 1, ACT_MAX);
    end
    pos = (len == 0) ? 0 : $urandom_range(0, len - 1);
    if (act == ACT_INSERT) pos = $urandom_range(0, len);
    if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, POS_MAX);
    pos2 = (len == 0) ? 0 : $urandom_range(0, len - 1);
    if ($urandom_range(0, 9) == 0) pos2 = $urandom_range(0, POS2_MAX);
    if ($urandom_range(0, 15) == 0) pos2 = pos % (POS2_MAX + 1);
    case ($urandom_range(0, 7))
      0: val = '0;
      1: val = '1;
      2, 3: val = $urandom_range(0, 3);
      default: val = $urandom;
    endcase
    if (act == ACT_REMOVE_VAL && len != 0 && $urandom_range(0, 4) != 0) begin
      val = list_words[$urandom_range(0, len - 1)];
    end
    push_op(act, pos, pos2, val);
  endtask

  always @(posedge clk) begin : drive_cmd
    list_op_t next_op;
    logic next_valid;
    if (!rst_n) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        predicted_q.push_back(apply_list_op(op_on_bus));
        ops_taken++;
      end
      next_valid = cmd_bus.valid && !cmd_bus.ready;
      if (!next_valid && pending_ops.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        next_op = pending_ops.pop_front();
        op_on_bus = next_op;
        cmd_bus.action <= next_op.action;
        cmd_bus.position <= next_op.position;
        cmd_bus.second_position <= next_op.second_position;
        cmd_bus.value <= next_op.value;
        next_valid = 1'b1;
      end
      cmd_bus.valid <= next_valid;
    end
  end

  always @(posedge clk) begin : check_rsp
    list_result_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got status %0b value %h count %0d",
                   $time, rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status mismatch, expected %0b, got %0b",
                     $time, want.status, rsp_bus.status);
            mismatches++;
          end
          if (rsp_bus.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %h, got %h",
                     $time, want.read_value, rsp_bus.read_value);
            mismatches++;
          end
          if (rsp_bus.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.entry_count, rsp_bus.entry_count);
            mismatches++;
          end
        end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin : run_stimulus
    int idle_by_round [ROUNDS];
    int stall_by_round [ROUNDS];
    bit growing;
    int r;
    int b;
    int k;
    idle_by_round = '{0, 52, 0, 36};
    stall_by_round = '{0, 0, 52, 36};
    rst_n = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.action = ACT_READ;
    cmd_bus.position = '0;
    cmd_bus.second_position = '0;
    cmd_bus.value = '0;
    rsp_bus.ready = 1'b0;
    for (k = 0; k < CAPACITY; k++) list_words[k] = '0;
    list_len = 0;
    ops_taken = 0;
    results_seen = 0;
    rejected_ops = 0;
    full_inserts = 0;
    peak_len = 0;
    mismatches = 0;
    sender_idle_pct = idle_by_round[0];
    receiver_stall_pct = stall_by_round[0];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, insert past the end, then build a short list and poke at its edges.
    push_op(ACT_READ, 0, 0, 32'h0);
    push_op(ACT_REMOVE, 0, 0, 32'h0);
    push_op(ACT_REMOVE_VAL, 0, 0, 32'h0);
    push_op(ACT_EXCHANGE, 0, 0, 32'h0);
    push_op(ACT_INSERT, 1, 0, 32'h1111_1111);
    push_op(ACT_INSERT, 0, 0, 32'hFFFF_FFFF);
    push_op(ACT_INSERT, 1, 0, 32'h0000_0000);
    push_op(ACT_INSERT, 0, 0, 32'h1234_5678);
    push_op(ACT_INSERT, 1, 0, 32'hA5A5_A5A5);
    push_op(ACT_INSERT, 0, 0, 32'h0000_0000);
    push_op(ACT_INSERT, POS_MAX, POS2_MAX, 32'h5A5A_5A5A);
    push_op(ACT_READ, 4, 0, 32'h0);
    push_op(ACT_READ, 5, 0, 32'h0);
    push_op(ACT_READ, CAPACITY, 0, 32'h0);
    push_op(ACT_EXCHANGE, 0, 4, 32'h0);
    push_op(ACT_EXCHANGE, 2, 2, 32'h0);
    push_op(ACT_EXCHANGE, 1, POS2_MAX, 32'h0);
    push_op(ACT_EXCHANGE, 5, 0, 32'h0);
    push_op(ACT_REMOVE_VAL, 0, 0, 32'h0000_0000);
    push_op(ACT_REMOVE_VAL, 0, 0, 32'hDEAD_BEEF);
    for (k = ACT_REMOVE_VAL + 1; k <= ACT_MAX; k++) push_op(k, 0, 0, 32'hFFFF_FFFF);
    push_op(ACT_REMOVE, 4, 0, 32'h0);
    push_op(ACT_REMOVE, 3, 0, 32'h0);
    push_op(ACT_REMOVE, 0, 0, 32'h0);
    push_op(ACT_READ, 1, 0, 32'h0);

    // Random traffic sweeps the list between empty and full, several times over.
    growing = 1'b1;
    for (r = 0; r < ROUNDS; r++) begin
      sender_idle_pct = idle_by_round[r];
      receiver_stall_pct = stall_by_round[r];
      for (b = 0; b < BATCHES; b++) begin
        while (pending_ops.size() > 1) @(negedge clk);
        for (k = 0; k < BATCH; k++) queue_random_op(growing);
        if (growing && list_len >= CAPACITY) growing = 1'b0;
        else if (!growing && list_len == 0) growing = 1'b1;
      end
    end

    while (pending_ops.size() != 0 || cmd_bus.valid || predicted_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d list actions, %0d of them rejected, and checked %0d results.",
             ops_taken, rejected_ops, results_seen);
    $display("The list peaked at %0d of %0d entries; %0d inserts met a full list.",
             peak_len, CAPACITY, full_inserts);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Run timed out with %0d results still outstanding.", predicted_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/positional_list_engine_top.sv
tb/tb.sv
